### hw/rtl/fixed_point_alu_q24_8_defines.svh
// ----------------------------------------------------------------------------
// Fixed-point ALU assertion macros
// Shared concurrent assertion forms, clocked on i_clk, quiet while in reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_Q24_8_DEFINES_SVH
`define FIXED_POINT_ALU_Q24_8_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define FPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Opcodes, default word format and pipeline constants.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int OP_WIDTH       = 4;
    localparam int MUL_LAT        = 3;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } t_op;

endpackage

`default_nettype wire

### hw/rtl/fpa_mul.sv
// ----------------------------------------------------------------------------
// Fixed-point multiplier
// Three-stage magnitude multiply: half-word partial products, full product
// sum, then fraction shift and sign restore.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_mul #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                  i_clk,
    input  wire logic [WORD_WIDTH-1:0] i_ma,
    input  wire logic [WORD_WIDTH-1:0] i_mb,
    input  wire logic                  i_neg,
    output logic      [WORD_WIDTH-1:0] o_prod
);

    localparam int H  = (WORD_WIDTH + 1) / 2;
    localparam int PW = 4 * H;

    logic [H-1:0]              a_lo, a_hi, b_lo, b_hi;
    logic [2*H-1:0]            r_p00, r_p01, r_p10, r_p11;
    logic                      r_neg1, r_neg2;
    logic [PW-1:0]             sum;
    logic [2*WORD_WIDTH-1:0]   r_prod;
    logic [2*WORD_WIDTH-1:0]   shifted;
    logic [WORD_WIDTH-1:0]     low_q;
    logic [WORD_WIDTH-1:0]     r_q;

    assign a_lo = i_ma[H-1:0];
    assign b_lo = i_mb[H-1:0];
    assign a_hi = H'(i_ma >> H);
    assign b_hi = H'(i_mb >> H);

    always_ff @(posedge i_clk) begin
        r_p00  <= (2*H)'(a_lo) * (2*H)'(b_lo);
        r_p01  <= (2*H)'(a_lo) * (2*H)'(b_hi);
        r_p10  <= (2*H)'(a_hi) * (2*H)'(b_lo);
        r_p11  <= (2*H)'(a_hi) * (2*H)'(b_hi);
        r_neg1 <= i_neg;
    end

    assign sum = PW'(r_p00) + (PW'(r_p01) << H) + (PW'(r_p10) << H)
               + (PW'(r_p11) << (2 * H));

    always_ff @(posedge i_clk) begin
        r_prod <= sum[2*WORD_WIDTH-1:0];
        r_neg2 <= r_neg1;
    end

    assign shifted = r_prod >> FRAC_BITS;
    assign low_q   = shifted[WORD_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        r_q <= r_neg2 ? (~low_q + WORD_WIDTH'(1)) : low_q;
    end

    assign o_prod = r_q;

endmodule

`default_nettype wire

### hw/rtl/fpa_div.sv
// ----------------------------------------------------------------------------
// Fixed-point divider
// Restoring magnitude divide, one quotient bit per stage over the scaled
// dividend; keeps the low word of the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_div #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                  i_clk,
    input  wire logic [WORD_WIDTH-1:0] i_ma,
    input  wire logic [WORD_WIDTH-1:0] i_mb,
    output logic      [WORD_WIDTH-1:0] o_quo
);

    localparam int STEPS = WORD_WIDTH + FRAC_BITS;

    logic [WORD_WIDTH-1:0] r_rem [STEPS];
    logic [WORD_WIDTH-1:0] r_quo [STEPS];
    logic [WORD_WIDTH-1:0] r_den [STEPS];
    logic [STEPS-1:0]      r_num [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [WORD_WIDTH-1:0] rem_in, quo_in, den_in;
        logic [STEPS-1:0]      num_in;
        logic [WORD_WIDTH:0]   shifted, diff;
        logic                  ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
            assign den_in = i_mb;
            assign num_in = {i_ma, {FRAC_BITS{1'b0}}};
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
            assign den_in = r_den[k-1];
            assign num_in = r_num[k-1];
        end

        assign shifted = {rem_in, num_in[STEPS-1]};
        assign diff    = shifted - {1'b0, den_in};
        assign ge      = ~diff[WORD_WIDTH];

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? diff[WORD_WIDTH-1:0] : shifted[WORD_WIDTH-1:0];
            r_quo[k] <= {quo_in[WORD_WIDTH-2:0], ge};
            r_den[k] <= den_in;
            r_num[k] <= num_in << 1;
        end
    end

    assign o_quo = r_quo[STEPS-1];

endmodule

`default_nettype wire

### hw/rtl/fixed_point_alu_q24_8.sv
// Path from start to o_done (Q24.8 or any other format): r_s0_vld, the r_vld chain, then o_done.
// Throughput: one beat per cycle; busy stays low, results never wait.
// The depth is set by the divider, one quotient bit per pipeline stage.
// Synchronous active-low reset clears all valid bits; beats in flight are dropped.
// ----------------------------------------------------------------------------
// Fixed-point ALU, signed Q24.8
// Pipelined add/sub/mul/div/compare/min/max/inc/dec/convert unit; every op takes the same
// path length so results leave in order.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fixed_point_alu_q24_8_defines.svh"

module fixed_point_alu_q24_8 #(
    parameter int WORD_WIDTH = fpa_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [fpa_pkg::OP_WIDTH-1:0]  i_op,
    input  wire logic signed [WORD_WIDTH-1:0]  i_operand_a,
    input  wire logic signed [WORD_WIDTH-1:0]  i_operand_b,
    output logic                               o_done,
    output logic signed [WORD_WIDTH-1:0]       o_result_value,
    output logic                               o_compare_true,
    output logic                               o_div_by_zero
);

    import fpa_pkg::*;

    localparam int DEPTH = WORD_WIDTH + FRAC_BITS;

    typedef struct packed {
        logic [WORD_WIDTH-1:0] res;
        logic                  cmp;
        logic                  dz;
        logic                  is_mul;
        logic                  is_div;
        logic                  neg;
    } t_side;

    logic [WORD_WIDTH-1:0] ua, ub, ma, mb;
    logic                  gt, lt, eq;
    t_side                 n_s0;
    t_side                 r_s0;
    logic                  r_s0_vld;
    logic [WORD_WIDTH-1:0] r_s0_ma, r_s0_mb;
    t_side                 r_sb [DEPTH];
    logic [DEPTH-1:0]      r_vld;
    logic [WORD_WIDTH-1:0] w_mul_prod;
    logic [WORD_WIDTH-1:0] w_quo;
    logic [WORD_WIDTH-1:0] quo_signed;
    t_side                 mul_merged;
    t_side                 last;

    assign busy = 1'b0;

    assign ua = i_operand_a;
    assign ub = i_operand_b;
    assign ma = ua[WORD_WIDTH-1] ? (~ua + WORD_WIDTH'(1)) : ua;
    assign mb = ub[WORD_WIDTH-1] ? (~ub + WORD_WIDTH'(1)) : ub;
    assign gt = i_operand_a > i_operand_b;
    assign lt = i_operand_a < i_operand_b;
    assign eq = (ua == ub);

    always_comb begin
        n_s0        = '0;
        n_s0.neg    = ua[WORD_WIDTH-1] ^ ub[WORD_WIDTH-1];
        case (t_op'(i_op))
            OP_ADD:      n_s0.res = ua + ub;
            OP_SUB:      n_s0.res = ua - ub;
            OP_MUL:      n_s0.is_mul = 1'b1;
            OP_DIV: begin
                n_s0.is_div = 1'b1;
                n_s0.dz     = (ub == '0);
            end
            OP_GT:       n_s0.cmp = gt;
            OP_LT:       n_s0.cmp = lt;
            OP_GE:       n_s0.cmp = !lt;
            OP_LE:       n_s0.cmp = !gt;
            OP_EQ:       n_s0.cmp = eq;
            OP_NE:       n_s0.cmp = !eq;
            OP_MIN:      n_s0.res = gt ? ub : ua;
            OP_MAX:      n_s0.res = lt ? ub : ua;
            OP_INC:      n_s0.res = ua + WORD_WIDTH'(1);
            OP_DEC:      n_s0.res = ua - WORD_WIDTH'(1);
            OP_FROM_INT: n_s0.res = ua << FRAC_BITS;
            OP_TO_INT:   n_s0.res = WORD_WIDTH'(i_operand_a >>> FRAC_BITS);
            default:     n_s0.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else begin
            r_s0_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0    <= n_s0;
        r_s0_ma <= ma;
        r_s0_mb <= mb;
    end

    fpa_mul #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_ma   (r_s0_ma),
        .i_mb   (r_s0_mb),
        .i_neg  (r_s0.neg),
        .o_prod (w_mul_prod)
    );

    fpa_div #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk (i_clk),
        .i_ma  (r_s0_ma),
        .i_mb  (r_s0_mb),
        .o_quo (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], r_s0_vld};
        end
    end

    always_comb begin
        mul_merged = r_sb[MUL_LAT-1];
        if (r_sb[MUL_LAT-1].is_mul) begin
            mul_merged.res = w_mul_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sb[0] <= r_s0;
        for (int k = 1; k < DEPTH; k++) begin
            r_sb[k] <= (k == MUL_LAT) ? mul_merged : r_sb[k-1];
        end
    end

    assign last       = r_sb[DEPTH-1];
    assign quo_signed = last.neg ? (~w_quo + WORD_WIDTH'(1)) : w_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done         <= 1'b0;
            o_compare_true <= 1'b0;
            o_div_by_zero  <= 1'b0;
        end else begin
            o_done         <= r_vld[DEPTH-1];
            o_compare_true <= r_vld[DEPTH-1] & last.cmp;
            o_div_by_zero  <= r_vld[DEPTH-1] & last.dz;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result_value <= (last.is_div && !last.dz) ? quo_signed : last.res;
    end

    `FPA_ASSERT_NOW(a_dz_zero_result, o_div_by_zero,
        o_done && o_result_value == '0 && !o_compare_true, "divide by zero beat malformed")
    `FPA_ASSERT_NOW(a_cmp_with_done, o_compare_true, o_done, "compare flag without beat")
    `FPA_ASSERT_NEXT(a_mul_merge, r_vld[MUL_LAT-1] && r_sb[MUL_LAT-1].is_mul,
        r_sb[MUL_LAT].res == $past(w_mul_prod), "product not merged into pipeline")

endmodule

`default_nettype wire
